@@ src/ljpf_pkg.sv @@
// Shared constants, types and widths of the Lennard-Jones pair force unit.
package ljpf_pkg;

  localparam int MAX_PARTICLES = 64;
  localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

  localparam int POS_W = 31;
  localparam int ACC_W = 48;
  localparam int MAG_W = 63;
  localparam int DEN_W = 46;
  localparam int IN_TDATA_W = 96;
  localparam int OUT_TDATA_W = 200;

  // Squared cutoff (3 sigma)^2 and sigma^2, both in Q40.
  localparam logic [63:0] RC2_Q40 = (64'd49 << 40) + ((64'd322529 << 40) / 64'd1000000);
  localparam logic [63:0] SIG2_Q40 = (64'd5 << 40) + ((64'd480281 << 40) / 64'd1000000);
  localparam logic [63:0] DIV_NUM = SIG2_Q40 << 21;
  // 48 * epsilon / sigma^2 scaled into Q32.
  localparam logic [63:0] K1_Q32 = (64'd4800000 << 32) / 64'd5480281;
  localparam logic [63:0] U_CLAMP = 64'd1 << 51;
  localparam logic [MAG_W-1:0] MAG_CAP = MAG_W'(64'd1 << 62);
  // ceil(2^66 / 5): a 64-bit value times this, shifted right by 66, is the value over five.
  localparam logic [63:0] RECIP5_Q66 = 64'hCCCC_CCCC_CCCC_CCCD;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 48'sh8000_0000_0000;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    pos_t x;
    pos_t y;
    pos_t z;
  } vec_t;

  typedef struct packed {
    logic start;
    vec_t pi;
    vec_t pj;
    pos_t box;
  } pair_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic hit;
    logic signed [ACC_W-1:0] fx;
    logic signed [ACC_W-1:0] fy;
    logic signed [ACC_W-1:0] fz;
    logic signed [ACC_W-1:0] pot;
  } pair_rsp_t;

endpackage

@@ src/ljpf_pair_calc.sv @@
// Sequenced arithmetic for one particle pair: minimum image, r^2, divider and multiplier.
module ljpf_pair_calc (
  input  logic                clk,
  input  logic                rst,
  input  ljpf_pkg::pair_req_t req,
  output ljpf_pkg::pair_rsp_t rsp
);

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_SQ   = 3'd1;
  localparam logic [2:0] P_CHK  = 3'd2;
  localparam logic [2:0] P_DIV  = 3'd3;
  localparam logic [2:0] P_MUL  = 3'd4;
  localparam logic [2:0] P_W    = 3'd5;
  localparam logic [2:0] P_DONE = 3'd6;

  localparam logic [3:0] OP_U2 = 4'd0;
  localparam logic [3:0] OP_U3 = 4'd1;
  localparam logic [3:0] OP_U4 = 4'd2;
  localparam logic [3:0] OP_U6 = 4'd3;
  localparam logic [3:0] OP_U7 = 4'd4;
  localparam logic [3:0] OP_FM = 4'd5;
  localparam logic [3:0] OP_FX = 4'd6;
  localparam logic [3:0] OP_FY = 4'd7;
  localparam logic [3:0] OP_FZ = 4'd8;
  localparam logic [3:0] OP_PT = 4'd9;

  localparam int MW = ljpf_pkg::MAG_W;
  localparam int DW = ljpf_pkg::DEN_W;

  logic [2:0] state;

  logic [30:0] dm [3];
  logic [2:0]  dneg;
  logic [1:0]  sq_cnt;
  logic [30:0] sq_op;
  logic [61:0] sq;
  logic [61:0] sq_prod;
  logic [63:0] r2;

  logic [63:0]   dv_quo;
  logic [DW-1:0] dv_rem;
  logic [DW-1:0] dv_den;
  logic [5:0]    dv_cnt;
  logic [DW:0]   dv_trial;
  logic          dv_ge;
  logic [63:0]   dv_quo_next;
  logic [63:0]   u_clamped;

  logic [3:0]   mop;
  logic [2:0]   mcnt;
  logic [63:0]  ma;
  logic [63:0]  mb;
  logic [31:0]  ma_h;
  logic [31:0]  mb_h;
  logic [63:0]  pp_prod;
  logic [63:0]  pp;
  logic [1:0]   pp_sh;
  logic [127:0] macc;
  logic [127:0] mshift;
  logic [MW-1:0] mres;

  logic [MW-1:0] u, u2, u3, u4, u6, u7, fm, wabs, pdabs;
  logic [MW-1:0] mag [3];
  logic [MW-1:0] potmag;
  logic          wneg;
  logic          pdneg;
  logic signed [63:0] wv;
  logic signed [63:0] pv;

  logic [31:0] mi_x, mi_y, mi_z;

  // Returns {sign, magnitude} of the corrected coordinate difference.
  function automatic logic [31:0] min_image(input logic [30:0] a, input logic [30:0] b,
                                            input logic [30:0] len);
    logic signed [33:0] df;
    logic signed [33:0] tw;
    logic signed [33:0] ln;
    logic signed [33:0] dd;
    logic signed [33:0] mg;
    df = $signed({3'b000, a}) - $signed({3'b000, b});
    tw = df <<< 1;
    ln = $signed({3'b000, len});
    if (tw >= ln) dd = df - ln;
    else if (tw <= -ln) dd = df + ln;
    else dd = df;
    mg = dd[33] ? -dd : dd;
    return {dd[33], mg[30:0]};
  endfunction

  function automatic logic signed [47:0] signed_sat(input logic [MW-1:0] m, input logic neg);
    if (|m[MW-1:47]) return neg ? ljpf_pkg::ACC_MIN : ljpf_pkg::ACC_MAX;
    return neg ? (48'sd0 - $signed({1'b0, m[46:0]})) : $signed({1'b0, m[46:0]});
  endfunction

  assign mi_x = min_image(req.pi.x, req.pj.x, req.box);
  assign mi_y = min_image(req.pi.y, req.pj.y, req.box);
  assign mi_z = min_image(req.pi.z, req.pj.z, req.box);

  assign sq_op = (sq_cnt == 2'd0) ? dm[0] : ((sq_cnt == 2'd1) ? dm[1] : dm[2]);
  assign sq_prod = {31'b0, sq_op} * {31'b0, sq_op};

  assign dv_trial = {dv_rem, dv_quo[63]};
  assign dv_ge = dv_trial >= {1'b0, dv_den};
  assign dv_quo_next = {dv_quo[62:0], dv_ge};
  assign u_clamped = (dv_quo_next > ljpf_pkg::U_CLAMP) ? ljpf_pkg::U_CLAMP : dv_quo_next;

  always_comb begin
    unique case (mop)
      OP_U2: begin ma = {1'b0, u};    mb = {1'b0, u}; end
      OP_U3: begin ma = {1'b0, u2};   mb = {1'b0, u}; end
      OP_U4: begin ma = {1'b0, u3};   mb = {1'b0, u}; end
      OP_U6: begin ma = {1'b0, u3};   mb = {1'b0, u3}; end
      OP_U7: begin ma = {1'b0, u6};   mb = {1'b0, u}; end
      OP_FM: begin ma = {1'b0, wabs}; mb = ljpf_pkg::K1_Q32; end
      OP_FX: begin ma = {1'b0, fm};   mb = {33'b0, dm[0]}; end
      OP_FY: begin ma = {1'b0, fm};   mb = {33'b0, dm[1]}; end
      OP_FZ: begin ma = {1'b0, fm};   mb = {33'b0, dm[2]}; end
      OP_PT: begin ma = {pdabs, 1'b0}; mb = ljpf_pkg::RECIP5_Q66; end
      default: begin ma = 64'd0; mb = 64'd0; end
    endcase
  end

  assign ma_h = mcnt[1] ? ma[63:32] : ma[31:0];
  assign mb_h = mcnt[0] ? mb[63:32] : mb[31:0];
  assign pp_prod = {32'b0, ma_h} * {32'b0, mb_h};

  // The potential takes twice |u^6 - u^3| over five and then drops 8 more bits.
  assign mshift = (mop == OP_PT) ? (macc >> 74) :
                  ((mop >= OP_FX) ? (macc >> 28) : (macc >> 32));
  assign mres = (mshift > {65'b0, ljpf_pkg::MAG_CAP}) ? ljpf_pkg::MAG_CAP : mshift[MW-1:0];

  assign wv = $signed({1'b0, u7}) - $signed({2'b00, u4[MW-1:1]});
  assign pv = $signed({1'b0, u6}) - $signed({1'b0, u3});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
    end else begin
      unique case (state)
        P_IDLE: begin
          if (req.start) begin
            dm[0] <= mi_x[30:0];
            dm[1] <= mi_y[30:0];
            dm[2] <= mi_z[30:0];
            dneg <= {mi_z[31], mi_y[31], mi_x[31]};
            sq <= '0;
            r2 <= '0;
            sq_cnt <= '0;
            macc <= '0;
            pp <= '0;
            mcnt <= '0;
            state <= P_SQ;
          end
        end
        P_SQ: begin
          sq <= sq_prod;
          r2 <= r2 + {2'b00, sq};
          sq_cnt <= sq_cnt + 2'd1;
          if (sq_cnt == 2'd3) state <= P_CHK;
        end
        P_CHK: begin
          if (r2 == 64'd0 || r2 >= ljpf_pkg::RC2_Q40) begin
            state <= P_DONE;
          end else begin
            dv_quo <= ljpf_pkg::DIV_NUM;
            dv_rem <= '0;
            dv_den <= r2[DW-1:0];
            dv_cnt <= '0;
            state <= P_DIV;
          end
        end
        P_DIV: begin
          dv_rem <= dv_ge ? DW'(dv_trial - {1'b0, dv_den}) : dv_trial[DW-1:0];
          dv_quo <= dv_quo_next;
          dv_cnt <= dv_cnt + 6'd1;
          if (dv_cnt == 6'd63) begin
            u <= {u_clamped[51:0], 11'b0};
            mop <= OP_U2;
            state <= P_MUL;
          end
        end
        P_MUL: begin
          if (mcnt == 3'd5) begin
            mcnt <= '0;
            macc <= '0;
            pp <= '0;
            unique case (mop)
              OP_U2: begin u2 <= mres; mop <= OP_U3; end
              OP_U3: begin u3 <= mres; mop <= OP_U4; end
              OP_U4: begin u4 <= mres; mop <= OP_U6; end
              OP_U6: begin u6 <= mres; mop <= OP_U7; end
              OP_U7: begin u7 <= mres; state <= P_W; end
              OP_FM: begin fm <= mres; mop <= OP_FX; end
              OP_FX: begin mag[0] <= mres; mop <= OP_FY; end
              OP_FY: begin mag[1] <= mres; mop <= OP_FZ; end
              OP_FZ: begin mag[2] <= mres; mop <= OP_PT; end
              OP_PT: begin potmag <= mres; state <= P_DONE; end
              default: state <= P_DONE;
            endcase
          end else begin
            // Partial product of this step, registered before it is summed into the wide sum.
            if (mcnt <= 3'd3) begin
              pp <= pp_prod;
              pp_sh <= {1'b0, mcnt[1]} + {1'b0, mcnt[0]};
            end
            macc <= macc + ({64'b0, pp} << {pp_sh, 5'b0});
            mcnt <= mcnt + 3'd1;
          end
        end
        P_W: begin
          wneg <= wv[63];
          wabs <= wv[63] ? MW'(-wv) : wv[MW-1:0];
          pdneg <= pv[63];
          pdabs <= pv[63] ? MW'(-pv) : pv[MW-1:0];
          mop <= OP_FM;
          state <= P_MUL;
        end
        P_DONE: state <= P_IDLE;
        default: state <= P_IDLE;
      endcase
    end
  end

  // The hit flag is meaningful only on the done cycle.
  assign rsp.busy = (state != P_IDLE);
  assign rsp.done = (state == P_DONE);
  assign rsp.hit = (r2 != 64'd0) && (r2 < ljpf_pkg::RC2_Q40);
  assign rsp.fx = signed_sat(mag[0], wneg ^ dneg[0]);
  assign rsp.fy = signed_sat(mag[1], wneg ^ dneg[1]);
  assign rsp.fz = signed_sat(mag[2], wneg ^ dneg[2]);
  assign rsp.pot = signed_sat(potmag, pdneg);

endmodule

@@ src/lennard_jones_pair_forces_unit.sv @@
// Top level of the Lennard-Jones pair force unit: particle store, pair sequencing, results.
//
// Positions stream in one beat per cycle until a beat with tlast, which closes the set
// (up to 64 particles; positions past that are dropped, the closing beat still starts the
// run). The unit then visits every pair i < j once, applies the minimum-image correction
// for the box edge held in the configuration register, and inside the cutoff of three
// sigma adds the pair force to particle i and subtracts it from particle j while summing
// the pair potential. Each pair in the cutoff runs through the pair engine's
// one-bit-per-cycle divider, which runs 64 steps for sigma^2/r^2, and its 32x32
// multiplier for each of the ten wide products (the potential's division by five is a
// product with a reciprocal); a pair outside the cutoff or coincident skips both. Each
// row of pairs passes through the row read, latch and write-back states, and each result
// through the output read, latch and wait states. Positions and the per-particle force
// sums live in two single-port-read memories with registered read data; force sums carry
// one valid flip-flop per entry, cleared when a run starts, so an entry never written
// reads as zero. The input is not ready while a run is being computed or emitted. The
// results come out one beat per particle in load order; the beat of the last particle
// carries tlast and the total potential, all other beats carry a zero potential.
module lennard_jones_pair_forces_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [30:0]  cfg_wr_data,    // box_length
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,        // pos_x[30:0], pos_y[61:31], pos_z[92:62], zero pad
  input  logic         s_tlast,        // last_particle
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [199:0] m_tdata,        // particle_index[5:0], force_x[53:6],
                                       // force_y[101:54], force_z[149:102],
                                       // potential_total[197:150], zero pad
  output logic         m_tlast         // last_result
);

  localparam logic [3:0] S_LOAD    = 4'd0;
  localparam logic [3:0] S_ROWRD   = 4'd1;
  localparam logic [3:0] S_ROWLAT  = 4'd2;
  localparam logic [3:0] S_COLRD   = 4'd3;
  localparam logic [3:0] S_COLLAT  = 4'd4;
  localparam logic [3:0] S_PAIR    = 4'd5;
  localparam logic [3:0] S_ROWWR   = 4'd6;
  localparam logic [3:0] S_OUTRD   = 4'd7;
  localparam logic [3:0] S_OUTLAT  = 4'd8;
  localparam logic [3:0] S_OUTWAIT = 4'd9;

  localparam int MAXP = ljpf_pkg::MAX_PARTICLES;
  localparam int IW = ljpf_pkg::IDX_W;
  localparam int CW = ljpf_pkg::CNT_W;

  typedef struct packed {
    logic signed [47:0] fx;
    logic signed [47:0] fy;
    logic signed [47:0] fz;
  } acc_t;

  logic [3:0] state;

  ljpf_pkg::pos_t box_length;
  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;
  logic [CW-1:0]  n;
  logic [IW-1:0]  i;
  logic [IW-1:0]  j;
  logic [IW-1:0]  o;
  logic           s_accept;

  ljpf_pkg::vec_t pos_mem [MAXP];
  ljpf_pkg::vec_t pos_rd;
  acc_t           acc_mem [MAXP];
  acc_t           acc_rd;
  logic [MAXP-1:0] acc_vld;
  logic [IW-1:0]  rd_addr;
  logic           acc_we;
  logic [IW-1:0]  acc_wa;
  acc_t           acc_wd;

  ljpf_pkg::vec_t pi;
  acc_t           fi;
  acc_t           fj;
  acc_t           fi_new;
  acc_t           fj_new;
  logic signed [47:0] pot;
  logic signed [47:0] pot_new;

  logic [5:0]         out_idx;
  acc_t               out_acc;
  logic signed [47:0] out_pot;
  logic               out_last;
  logic               o_is_last;

  ljpf_pkg::pair_req_t pair_req;
  ljpf_pkg::pair_rsp_t pair_rsp;

  // Saturating add or subtract on the 48-bit accumulator range.
  function automatic logic signed [47:0] sat_sum(input logic signed [47:0] a,
                                                 input logic signed [47:0] b,
                                                 input logic sub);
    logic signed [48:0] s;
    s = sub ? ($signed({a[47], a}) - $signed({b[47], b}))
            : ($signed({a[47], a}) + $signed({b[47], b}));
    if (s[48] != s[47]) return s[48] ? ljpf_pkg::ACC_MIN : ljpf_pkg::ACC_MAX;
    return s[47:0];
  endfunction

  ljpf_pair_calc u_pair (
    .clk (clk),
    .rst (rst),
    .req (pair_req),
    .rsp (pair_rsp)
  );

  assign s_tready = (state == S_LOAD);
  assign s_accept = s_tvalid && s_tready;
  assign count_next = (count < CW'(MAXP)) ? (count + CW'(1)) : count;
  assign o_is_last = ((CW'(o) + CW'(1)) == n);

  assign pair_req.start = (state == S_COLLAT);
  assign pair_req.pi = pi;
  assign pair_req.pj = pos_rd;
  assign pair_req.box = box_length;

  assign fi_new.fx = sat_sum(fi.fx, pair_rsp.fx, 1'b0);
  assign fi_new.fy = sat_sum(fi.fy, pair_rsp.fy, 1'b0);
  assign fi_new.fz = sat_sum(fi.fz, pair_rsp.fz, 1'b0);
  assign fj_new.fx = sat_sum(fj.fx, pair_rsp.fx, 1'b1);
  assign fj_new.fy = sat_sum(fj.fy, pair_rsp.fy, 1'b1);
  assign fj_new.fz = sat_sum(fj.fz, pair_rsp.fz, 1'b1);
  assign pot_new = sat_sum(pot, pair_rsp.pot, 1'b0);

  always_comb begin
    if (state == S_ROWRD) rd_addr = i;
    else if (state == S_COLRD) rd_addr = j;
    else rd_addr = o;
  end

  // Force sums for particle j go back right after a pair in the cutoff; the row owner i goes back
  // once its row is finished, so no entry is read while a write to it is outstanding.
  always_comb begin
    acc_we = 1'b0;
    acc_wa = i;
    acc_wd = fi;
    if (state == S_PAIR && pair_rsp.done && pair_rsp.hit) begin
      acc_we = 1'b1;
      acc_wa = j;
      acc_wd = fj_new;
    end else if (state == S_ROWWR) begin
      acc_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && (count < CW'(MAXP))) begin
      pos_mem[count[IW-1:0]] <= {s_tdata[30:0], s_tdata[61:31], s_tdata[92:62]};
    end
    pos_rd <= pos_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_wa] <= acc_wd;
    end
    acc_rd <= acc_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box_length <= ljpf_pkg::pos_t'(10485760);
    end else if (cfg_wr_en) begin
      box_length <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      acc_vld <= '0;
      pot <= '0;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (s_accept) begin
            count <= count_next;
            if (s_tlast) begin
              n <= count_next;
              count <= '0;
              acc_vld <= '0;
              pot <= '0;
              i <= '0;
              o <= '0;
              state <= (count_next >= CW'(2)) ? S_ROWRD : S_OUTRD;
            end
          end
        end
        S_ROWRD: state <= S_ROWLAT;
        S_ROWLAT: begin
          pi <= pos_rd;
          fi <= acc_vld[i] ? acc_rd : '0;
          j <= i + IW'(1);
          state <= S_COLRD;
        end
        S_COLRD: state <= S_COLLAT;
        S_COLLAT: begin
          fj <= acc_vld[j] ? acc_rd : '0;
          state <= S_PAIR;
        end
        S_PAIR: begin
          if (pair_rsp.done) begin
            if (pair_rsp.hit) begin
              fi <= fi_new;
              acc_vld[j] <= 1'b1;
              pot <= pot_new;
            end
            if ((CW'(j) + CW'(1)) < n) begin
              j <= j + IW'(1);
              state <= S_COLRD;
            end else begin
              state <= S_ROWWR;
            end
          end
        end
        S_ROWWR: begin
          acc_vld[i] <= 1'b1;
          if ((CW'(i) + CW'(2)) < n) begin
            i <= i + IW'(1);
            state <= S_ROWRD;
          end else begin
            state <= S_OUTRD;
          end
        end
        S_OUTRD: state <= S_OUTLAT;
        S_OUTLAT: begin
          out_idx <= 6'(o);
          out_acc <= acc_vld[o] ? acc_rd : '0;
          out_pot <= o_is_last ? pot : '0;
          out_last <= o_is_last;
          m_tvalid <= 1'b1;
          state <= S_OUTWAIT;
        end
        S_OUTWAIT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (out_last) begin
              state <= S_LOAD;
            end else begin
              o <= o + IW'(1);
              state <= S_OUTRD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign m_tdata = {2'b00, out_pot, out_acc.fz, out_acc.fy, out_acc.fx, out_idx};
  assign m_tlast = out_last;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    pair_req.start |-> !pair_rsp.busy)
    else $error("pair engine started while still busy");

  a_done_in_pair: assert property (@(posedge clk) disable iff (rst)
    pair_rsp.done |-> state == S_PAIR)
    else $error("pair result arrived outside the pair wait state");

  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready && state == S_OUTWAIT)
    else $error("result beat pending while input is open");
`endif

endmodule
